### hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg: shared types for the MIPS subset execute unit
// Operation codes, request and result payloads, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

	// Default depth of the data word store.
	localparam int MemWordsDef = 4096;

	// Index of the link register written by JAL.
	localparam logic [4:0] LinkReg = 5'd31;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADDI = 5'd1,
		OP_AND  = 5'd2,
		OP_BEQ  = 5'd3,
		OP_BGTZ = 5'd4,
		OP_BLEZ = 5'd5,
		OP_BNE  = 5'd6,
		OP_DIV  = 5'd7,
		OP_J    = 5'd8,
		OP_JAL  = 5'd9,
		OP_JR   = 5'd10,
		OP_LUI  = 5'd11,
		OP_LW   = 5'd12,
		OP_MFHI = 5'd13,
		OP_MFLO = 5'd14,
		OP_MULT = 5'd15,
		OP_NOP  = 5'd16,
		OP_OR   = 5'd17,
		OP_ROTR = 5'd18,
		OP_SLL  = 5'd19,
		OP_SLT  = 5'd20,
		OP_SRL  = 5'd21,
		OP_SUB  = 5'd22,
		OP_SW   = 5'd23,
		OP_XOR  = 5'd24
	} op_t;

	typedef struct packed {
		logic [4:0]         operation;
		logic [4:0]         src_reg;
		logic [4:0]         second_reg;
		logic [4:0]         dest_reg;
		logic [4:0]         base_reg;
		logic [4:0]         shift_amount;
		logic signed [15:0] imm_value;
		logic signed [15:0] offset_value;
		logic [25:0]        jump_target;
	} in_t;

	typedef struct packed {
		logic [31:0] pc_after;
		logic        reg_write_valid;
		logic [4:0]  reg_write_index;
		logic [31:0] reg_write_value;
		logic        hilo_written;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic        store_valid;
		logic [31:0] store_address;
		logic [31:0] store_data;
		logic        overflow_flag;
		logic        unknown_flag;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;
		logic accept;
		logic exec;
		logic mem;
		logic md_start;
		logic wb;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_mem;
		logic is_md;
		logic md_done;
	} sts_t;

endpackage

### hdl/mse_chan_if.sv
// ----------------------------------------------------------------------------
// mse_chan_if: valid/ready channel
// Carries one request or result payload with its handshake.
// ----------------------------------------------------------------------------
interface mse_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/mse_muldiv.sv
// ----------------------------------------------------------------------------
// mse_muldiv: multiply and divide unit
// Signed 32x32 multiply with a registered product; signed division by a
// restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mse_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] hi,
	output logic [31:0] lo
);

	logic        busy_q, fin_q, done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q, dsr_q, hi_q, lo_q;
	logic        rneg_q, qneg_q;
	logic [32:0] rem_sh, rem_sub;
	logic signed [63:0] prod;
	logic [31:0] mag_a, mag_b;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign rem_sh  = {rem_q[31:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign prod    = $signed(a) * $signed(b);
	assign mag_a   = a[31] ? (~a + 32'd1) : a;
	assign mag_b   = b[31] ? (~b + 32'd1) : b;

	// Sequencing of the unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= is_div && (b != 32'd0);
			fin_q  <= 1'b0;
			done_q <= !is_div || (b == 32'd0);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else if (fin_q) begin
			fin_q  <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands, partial results and the final HI and LO words.
	always_ff @(posedge clk) begin
		if (start) begin
			if (!is_div) begin
				hi_q <= prod[63:32];
				lo_q <= prod[31:0];
			end else if (b == 32'd0) begin
				hi_q <= a;
				lo_q <= '0;
			end else begin
				rem_q  <= '0;
				quo_q  <= mag_a;
				dsr_q  <= mag_b;
				rneg_q <= a[31];
				qneg_q <= a[31] ^ b[31];
			end
		end else if (busy_q) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end else if (fin_q) begin
			hi_q <= rneg_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];
			lo_q <= qneg_q ? (~quo_q + 32'd1) : quo_q;
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;

endmodule

### hdl/mse_dpath.sv
// ----------------------------------------------------------------------------
// mse_dpath: execute datapath
// Register file, data word store, execute logic, architectural state and
// the result register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module mse_dpath #(
	parameter int MEM_WORDS = mse_pkg::MemWordsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mse_pkg::cmd_t cmd,
	output mse_pkg::sts_t sts,
	input  mse_pkg::in_t  in_pay,
	output mse_pkg::out_t out_pay
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [29:0] MemLimit = 30'(MEM_WORDS);

	mse_pkg::in_t  instr_q;
	mse_pkg::op_t  op, in_op;
	mse_pkg::out_t out_q;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] ra_q, rb_q;
	logic        ra_v_q, rb_v_q;
	logic [4:0]  addr_a;
	logic [31:0] a, b;

	logic [31:0] dmem [MEM_WORDS];
	logic [AW-1:0] clr_cnt_q;
	logic [31:0] mrd_q;
	logic        inr_q;

	logic [31:0] pc_q, hi_q, lo_q, ptgt_q;
	logic        pend_q;

	logic        wr_q, ovf_q, unk_q, pset_q;
	logic [4:0]  widx_q;
	logic [31:0] wval_q, saddr_q, sdata_q, ptgt_n_q;

	logic        md_done;
	logic [31:0] md_hi, md_lo;

	logic [31:0] wb_val, hi_n, lo_n, pc_n;
	logic        is_md, st_v;

	assign op    = mse_pkg::op_t'(instr_q.operation);
	assign in_op = mse_pkg::op_t'(in_pay.operation);

	// Register file: read at request acceptance, written at writeback.
	assign addr_a = (in_op == mse_pkg::OP_LW || in_op == mse_pkg::OP_SW)
		? in_pay.base_reg : in_pay.src_reg;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			instr_q <= in_pay;
			ra_q    <= rf_mem[addr_a];
			rb_q    <= rf_mem[in_pay.second_reg];
		end
		if (cmd.wb && wr_q) begin
			rf_mem[widx_q] <= wb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			ra_v_q   <= 1'b0;
			rb_v_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				ra_v_q <= rf_vld_q[addr_a];
				rb_v_q <= rf_vld_q[in_pay.second_reg];
			end
			if (cmd.wb && wr_q) begin
				rf_vld_q[widx_q] <= 1'b1;
			end
		end
	end

	// Entries never written since reset read as zero.
	assign a = ra_v_q ? ra_q : '0;
	assign b = rb_v_q ? rb_q : '0;

	// Execute logic.
	logic [31:0] imm32, off32, mem_addr, rot_val, branch_to;
	logic [32:0] add33, sub33, addi33;
	logic [63:0] rot64;
	logic        x_wr, x_ovf, x_unk, x_pset;
	logic [4:0]  x_idx;
	logic [31:0] x_val, x_ptgt;

	assign imm32     = {{16{instr_q.imm_value[15]}}, instr_q.imm_value};
	assign off32     = {{16{instr_q.offset_value[15]}}, instr_q.offset_value};
	assign add33     = {a[31], a} + {b[31], b};
	assign sub33     = {a[31], a} - {b[31], b};
	assign addi33    = {a[31], a} + {imm32[31], imm32};
	assign mem_addr  = a + off32;
	assign branch_to = pc_q + off32 + 32'd1;
	assign rot64     = {b, b} >> instr_q.shift_amount;
	assign rot_val   = rot64[31:0];

	always_comb begin
		x_wr   = 1'b0;
		x_idx  = instr_q.dest_reg;
		x_val  = '0;
		x_ovf  = 1'b0;
		x_unk  = 1'b0;
		x_pset = 1'b0;
		x_ptgt = branch_to;
		unique case (op)
			mse_pkg::OP_ADD: begin
				x_ovf = add33[32] ^ add33[31];
				x_wr  = !x_ovf;
				x_val = add33[31:0];
			end
			mse_pkg::OP_SUB: begin
				x_ovf = sub33[32] ^ sub33[31];
				x_wr  = !x_ovf;
				x_val = sub33[31:0];
			end
			mse_pkg::OP_ADDI: begin
				x_ovf = addi33[32] ^ addi33[31];
				x_wr  = !x_ovf;
				x_idx = instr_q.second_reg;
				x_val = addi33[31:0];
			end
			mse_pkg::OP_AND: begin
				x_wr  = 1'b1;
				x_val = a & b;
			end
			mse_pkg::OP_OR: begin
				x_wr  = 1'b1;
				x_val = a | b;
			end
			mse_pkg::OP_XOR: begin
				x_wr  = 1'b1;
				x_val = a ^ b;
			end
			mse_pkg::OP_BEQ:  x_pset = (a == b);
			mse_pkg::OP_BNE:  x_pset = (a != b);
			mse_pkg::OP_BGTZ: x_pset = !a[31] && (a != 32'd0);
			mse_pkg::OP_BLEZ: x_pset = a[31] || (a == 32'd0);
			mse_pkg::OP_J: begin
				x_pset = 1'b1;
				x_ptgt = {6'd0, instr_q.jump_target};
			end
			mse_pkg::OP_JAL: begin
				x_pset = 1'b1;
				x_ptgt = {6'd0, instr_q.jump_target};
				x_wr   = 1'b1;
				x_idx  = mse_pkg::LinkReg;
				x_val  = pc_q + 32'd2;
			end
			mse_pkg::OP_JR: begin
				x_pset = 1'b1;
				x_ptgt = a;
			end
			mse_pkg::OP_LUI: begin
				x_wr  = 1'b1;
				x_idx = instr_q.second_reg;
				x_val = {instr_q.imm_value, 16'd0};
			end
			mse_pkg::OP_LW: begin
				x_wr  = 1'b1;
				x_idx = instr_q.second_reg;
			end
			mse_pkg::OP_MFHI: begin
				x_wr  = 1'b1;
				x_val = hi_q;
			end
			mse_pkg::OP_MFLO: begin
				x_wr  = 1'b1;
				x_val = lo_q;
			end
			mse_pkg::OP_ROTR: begin
				x_wr  = 1'b1;
				x_val = rot_val;
			end
			mse_pkg::OP_SLL: begin
				x_wr  = 1'b1;
				x_val = b << instr_q.shift_amount;
			end
			mse_pkg::OP_SRL: begin
				x_wr  = 1'b1;
				x_val = b >> instr_q.shift_amount;
			end
			mse_pkg::OP_SLT: begin
				x_wr  = 1'b1;
				x_val = {31'd0, $signed(a) < $signed(b)};
			end
			mse_pkg::OP_DIV, mse_pkg::OP_MULT, mse_pkg::OP_NOP, mse_pkg::OP_SW: begin
			end
			default: x_unk = 1'b1;
		endcase
	end

	// Execute results; a write to register zero is dropped but its index kept.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wr_q     <= x_wr && (x_idx != 5'd0);
			widx_q   <= x_wr ? x_idx : 5'd0;
			wval_q   <= (x_wr && (x_idx != 5'd0)) ? x_val : '0;
			ovf_q    <= x_ovf;
			unk_q    <= x_unk;
			pset_q   <= x_pset;
			ptgt_n_q <= x_ptgt;
			saddr_q  <= (op == mse_pkg::OP_LW || op == mse_pkg::OP_SW) ? mem_addr : '0;
			sdata_q  <= (op == mse_pkg::OP_SW) ? b : '0;
		end
	end

	// Data word store: clearing pass after reset, then one access per load or store.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			dmem[clr_cnt_q] <= '0;
		end else if (cmd.mem && op == mse_pkg::OP_SW && saddr_q[31:2] < MemLimit) begin
			dmem[saddr_q[AW+1:2]] <= sdata_q;
		end
		if (cmd.mem) begin
			mrd_q <= dmem[saddr_q[AW+1:2]];
			inr_q <= saddr_q[31:2] < MemLimit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Multiply and divide unit.
	mse_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.is_div (op == mse_pkg::OP_DIV),
		.a      (a),
		.b      (b),
		.done   (md_done),
		.hi     (md_hi),
		.lo     (md_lo)
	);

	// Writeback values.
	assign is_md  = (op == mse_pkg::OP_MULT || op == mse_pkg::OP_DIV);
	assign wb_val = !wr_q ? '0 : (op == mse_pkg::OP_LW) ? (inr_q ? mrd_q : '0) : wval_q;
	assign hi_n   = is_md ? md_hi : hi_q;
	assign lo_n   = is_md ? md_lo : lo_q;
	assign pc_n   = pend_q ? ptgt_q : pc_q + 32'd1;
	assign st_v   = (op == mse_pkg::OP_SW) && inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			pend_q <= 1'b0;
			ptgt_q <= '0;
		end else if (cmd.wb) begin
			pc_q   <= pc_n;
			hi_q   <= hi_n;
			lo_q   <= lo_n;
			pend_q <= pset_q;
			if (pset_q) begin
				ptgt_q <= ptgt_n_q;
			end
		end
	end

	// Result register; the store address is reported for SW only.
	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			out_q.pc_after        <= pc_n;
			out_q.reg_write_valid <= wr_q;
			out_q.reg_write_index <= widx_q;
			out_q.reg_write_value <= wb_val;
			out_q.hilo_written    <= is_md;
			out_q.hi_value        <= hi_n;
			out_q.lo_value        <= lo_n;
			out_q.store_valid     <= st_v;
			out_q.store_address   <= (op == mse_pkg::OP_SW) ? saddr_q : '0;
			out_q.store_data      <= sdata_q;
			out_q.overflow_flag   <= ovf_q;
			out_q.unknown_flag    <= unk_q;
		end
	end

	assign out_pay      = out_q;
	assign sts.clr_last = (clr_cnt_q == AW'(MEM_WORDS - 1));
	assign sts.is_mem   = (op == mse_pkg::OP_LW || op == mse_pkg::OP_SW);
	assign sts.is_md    = is_md;
	assign sts.md_done  = md_done;

endmodule

### hdl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl: execute controller
// Sequences clearing, execute, memory access, multiply/divide wait and
// writeback, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module mse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mse_pkg::sts_t sts,
	output mse_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_MEM   = 6'b001000,
		S_MD    = 6'b010000,
		S_WB    = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   wb_ok;

	// Writeback may proceed once the result register is free or being taken.
	assign wb_ok = !out_valid_q || out_ready;

	always_comb begin
		state_n      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.md_start = sts.is_md;
				state_n      = sts.is_mem ? S_MEM : (sts.is_md ? S_MD : S_WB);
			end
			S_MEM: begin
				cmd.mem = 1'b1;
				state_n = S_WB;
			end
			S_MD: begin
				if (sts.md_done) begin
					state_n = S_WB;
				end
			end
			S_WB: begin
				if (wb_ok) begin
					cmd.wb  = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit: MIPS32 integer subset execute unit
// Executes one decoded instruction per request and reports its effects.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the data store to zero, one word per cycle, so
// it takes no request until the sweep is done. Thereafter one instruction is
// in work at a time: most pass through register read, execute and writeback,
// LW and SW add an access through the registered data store port, and MULT
// and DIV wait for the registered multiplier or for the divider, which
// resolves one quotient bit per cycle (skipped when the divisor is zero).
// A result waiting in the output register does not stop the next request
// from being accepted; only its writeback waits.
module mips_subset_execute_unit #(
	parameter int MEM_WORDS = mse_pkg::MemWordsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	mse_chan_if.sink   in_ch,
	mse_chan_if.source out_ch
);

	mse_pkg::cmd_t cmd;
	mse_pkg::sts_t sts;
	mse_pkg::out_t out_pay;

	mse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mse_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_pay  (in_ch.payload),
		.out_pay (out_pay)
	);

	assign out_ch.payload = out_pay;

	// No request is taken while the data store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !in_ch.ready)
		else $error("request accepted during clearing pass");

	// Writeback never overwrites a result that is still waiting.
	a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> (!out_ch.valid || out_ch.ready))
		else $error("result overwritten before it was taken");

	// An accepted request is executed in the following cycle.
	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> cmd.exec)
		else $error("accepted request not executed");

	// Controller phases are mutually exclusive.
	a_phase_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.accept, cmd.exec, cmd.mem, cmd.wb}))
		else $error("overlapping controller phases");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mips_subset_execute_unit
// A table of directed instructions, then random instruction streams, is
// pushed through the request channel. A behavioural model of the execute
// unit predicts each result, which is compared field by field with the
// output channel. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HalfPeriod = 2;
	localparam int CycleLimit = 600000;
	localparam int RandomItems = 1300;

	logic clk;
	logic arst_n;

	mse_chan_if #(.T(mse_pkg::in_t))  req_ch ();
	mse_chan_if #(.T(mse_pkg::out_t)) res_ch ();

	mips_subset_execute_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (res_ch)
	);

	// Model state of the execute unit.
	logic [31:0] gpr [32];
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] pc_q;
	logic        pend_q;
	logic [31:0] pend_tgt_q;
	logic [31:0] dmem [mse_pkg::MemWordsDef];

	mse_pkg::out_t results_due[$];
	int   errors;
	int   cycles;
	int   results_seen;
	int   send_idle;
	int   recv_idle;

	// Directed instruction table, with typed results where obvious.
	typedef struct {
		mse_pkg::in_t  req;
		bit            typed;
		mse_pkg::out_t res;
	} row_t;

	row_t rows[$];

	initial begin
		clk = 1'b0;
	end

	always #(HalfPeriod) clk = ~clk;

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("mips_subset_execute_unit: mismatch");
			$finish;
		end
	end

	// Executes one instruction on the model state and returns its effects.
	function automatic mse_pkg::out_t execute_instr(mse_pkg::in_t q);
		mse_pkg::out_t o;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] off;
		logic [31:0] br_to;
		logic [32:0] wide;
		logic [31:0] addr;
		longint      prod;
		bit          old_pend;
		logic [31:0] old_tgt;
		bit          wr;
		a = gpr[q.src_reg];
		b = gpr[q.second_reg];
		imm = {{16{q.imm_value[15]}}, q.imm_value};
		off = {{16{q.offset_value[15]}}, q.offset_value};
		br_to = pc_q + off + 32'd1;
		old_pend = pend_q;
		old_tgt = pend_tgt_q;
		o = '0;
		wr = 1'b0;
		pend_q = 1'b0;
		case (q.operation)
			mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_ADDI: begin
				if (q.operation == mse_pkg::OP_ADD)
					wide = {a[31], a} + {b[31], b};
				else if (q.operation == mse_pkg::OP_SUB)
					wide = {a[31], a} - {b[31], b};
				else
					wide = {a[31], a} + {imm[31], imm};
				if (wide[32] != wide[31]) begin
					o.overflow_flag = 1'b1;
				end else begin
					wr = 1'b1;
					o.reg_write_index = (q.operation == mse_pkg::OP_ADDI)
						? q.second_reg : q.dest_reg;
					o.reg_write_value = wide[31:0];
				end
			end
			mse_pkg::OP_AND, mse_pkg::OP_OR, mse_pkg::OP_XOR, mse_pkg::OP_ROTR,
			mse_pkg::OP_SLL, mse_pkg::OP_SLT, mse_pkg::OP_SRL, mse_pkg::OP_MFHI,
			mse_pkg::OP_MFLO: begin
				wr = 1'b1;
				o.reg_write_index = q.dest_reg;
				case (q.operation)
					mse_pkg::OP_AND:  o.reg_write_value = a & b;
					mse_pkg::OP_OR:   o.reg_write_value = a | b;
					mse_pkg::OP_XOR:  o.reg_write_value = a ^ b;
					mse_pkg::OP_SLL:  o.reg_write_value = b << q.shift_amount;
					mse_pkg::OP_SRL:  o.reg_write_value = b >> q.shift_amount;
					mse_pkg::OP_SLT:
						o.reg_write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					mse_pkg::OP_MFHI: o.reg_write_value = hi_q;
					mse_pkg::OP_MFLO: o.reg_write_value = lo_q;
					default: begin
						if (q.shift_amount == 5'd0)
							o.reg_write_value = b;
						else
							o.reg_write_value = (b >> q.shift_amount)
								| (b << (6'd32 - q.shift_amount));
					end
				endcase
			end
			mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_BGTZ, mse_pkg::OP_BLEZ: begin
				if ((q.operation == mse_pkg::OP_BEQ && a == b)
						|| (q.operation == mse_pkg::OP_BNE && a != b)
						|| (q.operation == mse_pkg::OP_BGTZ && $signed(a) > 0)
						|| (q.operation == mse_pkg::OP_BLEZ && $signed(a) <= 0)) begin
					pend_q = 1'b1;
					pend_tgt_q = br_to;
				end
			end
			mse_pkg::OP_DIV: begin
				if (b == 32'd0) begin
					hi_q = a;
					lo_q = 32'd0;
				end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
					hi_q = 32'd0;
					lo_q = a;
				end else begin
					hi_q = $signed(a) % $signed(b);
					lo_q = $signed(a) / $signed(b);
				end
				o.hilo_written = 1'b1;
			end
			mse_pkg::OP_MULT: begin
				prod = longint'($signed(a)) * longint'($signed(b));
				lo_q = prod[31:0];
				hi_q = prod[63:32];
				o.hilo_written = 1'b1;
			end
			mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_JR: begin
				pend_q = 1'b1;
				pend_tgt_q = (q.operation == mse_pkg::OP_JR) ? a : {6'd0, q.jump_target};
				if (q.operation == mse_pkg::OP_JAL) begin
					wr = 1'b1;
					o.reg_write_index = mse_pkg::LinkReg;
					o.reg_write_value = pc_q + 32'd2;
				end
			end
			mse_pkg::OP_LUI: begin
				wr = 1'b1;
				o.reg_write_index = q.second_reg;
				o.reg_write_value = {imm[15:0], 16'd0};
			end
			mse_pkg::OP_LW: begin
				addr = gpr[q.base_reg] + off;
				wr = 1'b1;
				o.reg_write_index = q.second_reg;
				o.reg_write_value = ((addr >> 2) < mse_pkg::MemWordsDef)
					? dmem[addr >> 2] : 32'd0;
			end
			mse_pkg::OP_SW: begin
				addr = gpr[q.base_reg] + off;
				o.store_address = addr;
				o.store_data = b;
				if ((addr >> 2) < mse_pkg::MemWordsDef) begin
					dmem[addr >> 2] = b;
					o.store_valid = 1'b1;
				end
			end
			mse_pkg::OP_NOP: begin
			end
			default: o.unknown_flag = 1'b1;
		endcase
		// Writes to register zero are dropped and reported as no write.
		if (wr && o.reg_write_index == 5'd0) begin
			wr = 1'b0;
			o.reg_write_value = 32'd0;
		end
		if (wr)
			gpr[o.reg_write_index] = o.reg_write_value;
		o.reg_write_valid = wr;
		pc_q = old_pend ? old_tgt : pc_q + 32'd1;
		o.pc_after = pc_q;
		o.hi_value = hi_q;
		o.lo_value = lo_q;
		return o;
	endfunction

	// Offers one request and waits for it to be taken.
	task automatic send_req(input mse_pkg::in_t q, input bit typed,
			input mse_pkg::out_t res);
		bit            took;
		mse_pkg::out_t pred;
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.payload <= q;
		req_ch.valid <= 1'b1;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			@(posedge clk);
		end while (!took);
		pred = execute_instr(q);
		results_due.push_back(typed ? res : pred);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s: expected %h, actual %h", $realtime, name, want, got);
		end
	endtask

	// Result side: random ready, one long hold-off, and checking.
	initial begin : result_side
		bit            fire;
		mse_pkg::out_t got;
		mse_pkg::out_t want;
		int            hold_left;
		bit            held;
		hold_left = 0;
		held = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			fire = res_ch.valid && res_ch.ready;
			got = res_ch.payload;
			@(posedge clk);
			if (fire) begin
				results_seen++;
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, actual %p", $realtime, got);
				end else begin
					want = results_due.pop_front();
					check_field("pc_after", want.pc_after, got.pc_after);
					check_field("reg_write_valid", 32'(want.reg_write_valid),
						32'(got.reg_write_valid));
					check_field("reg_write_index", 32'(want.reg_write_index),
						32'(got.reg_write_index));
					check_field("reg_write_value", want.reg_write_value, got.reg_write_value);
					check_field("hilo_written", 32'(want.hilo_written),
						32'(got.hilo_written));
					check_field("hi_value", want.hi_value, got.hi_value);
					check_field("lo_value", want.lo_value, got.lo_value);
					check_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
					check_field("store_address", want.store_address, got.store_address);
					check_field("store_data", want.store_data, got.store_data);
					check_field("overflow_flag", 32'(want.overflow_flag),
						32'(got.overflow_flag));
					check_field("unknown_flag", 32'(want.unknown_flag),
						32'(got.unknown_flag));
				end
			end
			if (results_seen == 150 && !held) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic mse_pkg::in_t mk(mse_pkg::op_t op, int rs, int rt, int rd,
			int base, int sa, int imm, int off, int tgt);
		mse_pkg::in_t q;
		q.operation = op;
		q.src_reg = 5'(rs);
		q.second_reg = 5'(rt);
		q.dest_reg = 5'(rd);
		q.base_reg = 5'(base);
		q.shift_amount = 5'(sa);
		q.imm_value = 16'(imm);
		q.offset_value = 16'(off);
		q.jump_target = 26'(tgt);
		return q;
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
	endfunction

	function automatic logic [15:0] pick_half();
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(15));
			3: return 16'hFFFF - 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Random instruction, mostly well formed with in-range memory addressing.
	function automatic mse_pkg::in_t random_req();
		mse_pkg::in_t q;
		q.operation = ($urandom_range(99) < 4) ? 5'($urandom_range(31, 25))
			: 5'($urandom_range(24));
		q.src_reg = pick_reg();
		q.second_reg = pick_reg();
		q.dest_reg = pick_reg();
		q.base_reg = ($urandom_range(2) == 0) ? pick_reg() : 5'd0;
		q.shift_amount = 5'($urandom);
		q.imm_value = pick_half();
		if ((q.operation == mse_pkg::OP_LW || q.operation == mse_pkg::OP_SW)
				&& $urandom_range(3) != 0)
			q.offset_value = 16'($urandom_range(63) * 4 + $urandom_range(3));
		else if ($urandom_range(1) == 0)
			q.offset_value = 16'($signed(6'($urandom)));
		else
			q.offset_value = pick_half();
		q.jump_target = ($urandom_range(1) == 0) ? 26'($urandom_range(255)) : 26'($urandom);
		return q;
	endfunction

	// Fills the directed table.
	task automatic load_rows();
		row_t r;
		r.typed = 1'b0;
		r.res = '0;
		r.typed = 1'b1; r.req = mk(mse_pkg::OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0);
		r.res = '0; r.res.pc_after = 32'd1; rows.push_back(r);
		r.req = '1; r.res = '0; r.res.pc_after = 32'd2; r.res.unknown_flag = 1'b1;
		rows.push_back(r);
		r.req = mk(mse_pkg::OP_LUI, 0, 1, 0, 0, 0, 16'h8000, 0, 0); r.res = '0;
		r.res.pc_after = 32'd3; r.res.reg_write_valid = 1'b1; r.res.reg_write_index = 5'd1;
		r.res.reg_write_value = 32'h8000_0000; rows.push_back(r);
		r.typed = 1'b0;
		r.req = mk(mse_pkg::OP_LUI, 0, 2, 0, 0, 0, 16'hFFFF, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_ADDI, 0, 3, 0, 0, 0, -1, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_ADDI, 0, 4, 0, 0, 0, 32767, 0, 0); rows.push_back(r);
		// Signed overflow on ADD suppresses the write.
		r.typed = 1'b1; r.req = mk(mse_pkg::OP_ADD, 1, 1, 5, 0, 0, 0, 0, 0); r.res = '0;
		r.res.pc_after = 32'd7; r.res.overflow_flag = 1'b1; rows.push_back(r);
		r.typed = 1'b0;
		r.req = mk(mse_pkg::OP_SUB, 1, 3, 6, 0, 0, 0, 0, 0); rows.push_back(r);
		// Most negative divided by minus one.
		r.typed = 1'b1; r.req = mk(mse_pkg::OP_DIV, 1, 3, 0, 0, 0, 0, 0, 0); r.res = '0;
		r.res.pc_after = 32'd9; r.res.hilo_written = 1'b1; r.res.lo_value = 32'h8000_0000;
		rows.push_back(r);
		// Division by zero.
		r.req = mk(mse_pkg::OP_DIV, 4, 0, 0, 0, 0, 0, 0, 0); r.res = '0;
		r.res.pc_after = 32'd10; r.res.hilo_written = 1'b1; r.res.hi_value = 32'd32767;
		rows.push_back(r);
		r.typed = 1'b0;
		r.req = mk(mse_pkg::OP_MULT, 3, 1, 0, 0, 0, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_MFHI, 0, 0, 7, 0, 0, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_MFLO, 0, 0, 8, 0, 0, 0, 0, 0); rows.push_back(r);
		// Store outside the data store is reported but not written.
		r.typed = 1'b1; r.req = mk(mse_pkg::OP_SW, 0, 2, 0, 0, 0, 0, -4, 0); r.res = '0;
		r.res.pc_after = 32'd14; r.res.store_address = 32'hFFFF_FFFC;
		r.res.store_data = 32'hFFFF_0000; r.res.lo_value = 32'h8000_0000;
		rows.push_back(r);
		r.typed = 1'b0;
		r.req = mk(mse_pkg::OP_SW, 0, 3, 0, 0, 0, 0, 8, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_LW, 0, 9, 0, 0, 0, 0, 8, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_ADDI, 3, 0, 0, 0, 0, 5, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_SLL, 0, 3, 10, 0, 31, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_SRL, 0, 3, 11, 0, 1, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_ROTR, 0, 2, 12, 0, 4, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_SLT, 1, 0, 13, 0, 0, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_XOR, 2, 3, 14, 0, 0, 0, 0, 0); rows.push_back(r);
		// Branch in the delay slot of a jump, then return through the link.
		r.req = mk(mse_pkg::OP_JAL, 0, 0, 0, 0, 0, 0, 0, 26'h3FF_FFFF); rows.push_back(r);
		r.req = mk(mse_pkg::OP_BEQ, 0, 0, 0, 0, 0, 0, -32768, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_JR, 31, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_BGTZ, 4, 0, 0, 0, 0, 0, 32767, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_BLEZ, 1, 0, 0, 0, 0, 0, 3, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_BNE, 1, 2, 0, 0, 0, 0, 2, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_J, 0, 0, 0, 0, 0, 0, 0, 5); rows.push_back(r);
		r.req = mk(mse_pkg::OP_OR, 1, 4, 15, 0, 0, 0, 0, 0); rows.push_back(r);
		r.req = mk(mse_pkg::OP_AND, 2, 3, 16, 0, 0, 0, 0, 0); rows.push_back(r);
	endtask

	// Main sequence: reset, directed table, three random phases, drain.
	initial begin : stimulus
		mse_pkg::out_t none;
		int            phase;
		none = '0;
		errors = 0;
		results_seen = 0;
		send_idle = 20;
		recv_idle = 85;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		for (int i = 0; i < 32; i++)
			gpr[i] = 32'd0;
		for (int i = 0; i < mse_pkg::MemWordsDef; i++)
			dmem[i] = 32'd0;
		hi_q = 32'd0;
		lo_q = 32'd0;
		pc_q = 32'd0;
		pend_q = 1'b0;
		pend_tgt_q = 32'd0;
		load_rows();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_req(rows[i].req, rows[i].typed, rows[i].res);
		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 20 : (phase == 1) ? 85 : 0;
			recv_idle = (phase == 0) ? 85 : (phase == 1) ? 20 : 0;
			repeat (RandomItems / 3)
				send_req(random_req(), 1'b0, none);
		end
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("mips_subset_execute_unit: match");
		else
			$display("mips_subset_execute_unit: mismatch");
		$finish;
	end

endmodule
